### rtl/etsa_pkg.sv
// Package for the exact-time stream aligner.
// Sizes, field types and controller command/status structs; no dependencies.
package etsa_pkg;
	localparam int MAX_CHANNELS = 4;
	localparam int QUEUE_DEPTH = 16;
	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = CH_W + PTR_W;
	localparam int ACT_W = $clog2(MAX_CHANNELS + 1);

	typedef logic [63:0] stamp_t;

	// controller to datapath
	typedef struct packed {
		logic push;       // append the captured item to its queue
		logic scan_start; // set the all-same flag for a new scan
		logic rd;         // read head of scan channel
		logic acc;        // fold read head into min / equality check
		logic pop_eq;     // pop the read head if it equals the minimum
		logic emit;       // drive a matched result from the read head and pop
		logic drop;       // drive the full-queue status result
		logic [CH_W-1:0] sel;
		logic is_last;
	} etsa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;      // captured channel queue is full
		logic all_full;  // every active queue holds an item
		logic all_same;  // every scanned head equals the minimum
		logic [ACT_W-1:0] n_act;
	} etsa_sts_t;
endpackage

### rtl/etsa_datapath.sv
// Datapath: queue memories, pointers, fill counts, minimum scan and result regs.
// Depends on etsa_pkg.
module etsa_datapath import etsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cap,
	input  logic [2:0] channel,
	input  logic [31:0] stamp_sec,
	input  logic [31:0] stamp_nanosec,
	input  logic [31:0] payload,
	input  logic cfg_we,
	input  logic [3:0] cfg_data,
	input  etsa_cmd_t cmd,
	output etsa_sts_t sts,
	output logic in_active,
	output logic strobe,
	output logic status,
	output logic [2:0] out_channel,
	output logic [31:0] out_payload,
	output logic [31:0] match_sec,
	output logic [31:0] match_nanosec,
	output logic last
);
	localparam int DEPTH = MAX_CHANNELS * QUEUE_DEPTH;

	logic [63:0] stamp_mem [DEPTH];
	logic [31:0] pay_mem [DEPTH];
	logic [PTR_W-1:0] head_q [MAX_CHANNELS];
	logic [CNT_W-1:0] fill_q [MAX_CHANNELS];
	logic [3:0] act_q;
	logic [CH_W-1:0] ch_q;
	logic [63:0] stamp_q;
	logic [31:0] pay_q;
	logic [63:0] rd_stamp_q, min_q;
	logic [31:0] rd_pay_q;
	logic same_q;
	logic [ACT_W-1:0] n_act;
	logic [PTR_W-1:0] wr_ptr;
	logic [63:0] rd_key, min_key;
	logic eq_min;

	// effective active count
	always_comb begin
		if (act_q > 4'(MAX_CHANNELS)) n_act = ACT_W'(MAX_CHANNELS);
		else n_act = ACT_W'(act_q);
	end
	assign in_active = ({1'b0, channel} < 4'(n_act));

	always_comb begin
		sts.n_act = n_act;
		sts.full = (fill_q[ch_q] == CNT_W'(QUEUE_DEPTH));
		sts.all_full = 1'b1;
		for (int c = 0; c < MAX_CHANNELS; c++)
			if (c < int'(n_act) && fill_q[c] == '0) sts.all_full = 1'b0;
		sts.all_same = same_q;
	end

	assign wr_ptr = PTR_W'(head_q[ch_q] + fill_q[ch_q]);
	assign rd_key = rd_stamp_q ^ {1'b1, 63'b0};
	assign min_key = min_q ^ {1'b1, 63'b0};
	assign eq_min = (rd_stamp_q == min_q);

	// memories
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stamp_mem[{ch_q, wr_ptr}] <= stamp_q;
			pay_mem[{ch_q, wr_ptr}] <= pay_q;
		end
		if (cmd.rd) begin
			rd_stamp_q <= stamp_mem[{cmd.sel, head_q[cmd.sel]}];
			rd_pay_q <= pay_mem[{cmd.sel, head_q[cmd.sel]}];
		end
	end

	// capture, scan accumulators
	always_ff @(posedge clk) begin
		if (cap) begin
			ch_q <= CH_W'(channel);
			stamp_q <= {stamp_sec, stamp_nanosec};
			pay_q <= payload;
		end
		if (cmd.scan_start) same_q <= 1'b1;
		if (cmd.acc) begin
			if (cmd.sel == '0 || rd_key < min_key) min_q <= rd_stamp_q;
			if (cmd.sel != '0 && !eq_min) same_q <= 1'b0;
		end
	end

	// queue pointers, config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 4'd2;
			for (int c = 0; c < MAX_CHANNELS; c++) begin
				head_q[c] <= '0;
				fill_q[c] <= '0;
			end
		end else begin
			if (cfg_we) act_q <= cfg_data;
			if (cmd.push) fill_q[ch_q] <= fill_q[ch_q] + 1'b1;
			if (cmd.emit || (cmd.pop_eq && eq_min)) begin
				head_q[cmd.sel] <= head_q[cmd.sel] + 1'b1;
				fill_q[cmd.sel] <= fill_q[cmd.sel] - 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe <= 1'b0;
		else strobe <= cmd.emit | cmd.drop;
	end
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status <= 1'b0;
			out_channel <= 3'(cmd.sel);
			out_payload <= rd_pay_q;
			{match_sec, match_nanosec} <= min_q;
			last <= cmd.is_last;
		end else if (cmd.drop) begin
			status <= 1'b1;
			out_channel <= 3'(ch_q);
			out_payload <= pay_q;
			{match_sec, match_nanosec} <= stamp_q;
			last <= 1'b1;
		end
	end
endmodule

### rtl/etsa_ctrl.sv
// Controller: sequences push, min scan, equality check, pop, drop and emit passes.
// Depends on etsa_pkg.
module etsa_ctrl import etsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic in_active,
	input  etsa_sts_t sts,
	output logic busy,
	output logic cap,
	output etsa_cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PUSH = 3'd1;
	localparam logic [2:0] S_CHK  = 3'd2;
	localparam logic [2:0] S_MIN  = 3'd3;
	localparam logic [2:0] S_EQ   = 3'd4;
	localparam logic [2:0] S_POP  = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;

	logic [2:0] state_q;
	logic [CH_W-1:0] idx_q;
	logic acc_q; // read data valid for idx_q-1 style pipelining
	logic [CH_W-1:0] prev_q;

	assign busy = (state_q != S_IDLE);
	assign cap = start && !busy && in_active;

	// each pass: read head idx, act on it next cycle
	always_comb begin
		cmd = '0;
		cmd.sel = idx_q;
		case (state_q)
			S_PUSH: begin
				cmd.push = !sts.full;
				cmd.drop = sts.full;
			end
			S_CHK: begin
				cmd.scan_start = 1'b1;
				cmd.rd = sts.all_full;
			end
			S_MIN, S_EQ, S_POP, S_EMIT: begin
				if (acc_q) begin
					cmd.sel = prev_q;
					cmd.acc = (state_q == S_MIN) || (state_q == S_EQ);
					cmd.pop_eq = (state_q == S_POP);
					cmd.emit = (state_q == S_EMIT);
					cmd.is_last = ({1'b0, prev_q} == ACT_W'(sts.n_act - 1'b1));
				end else begin
					cmd.rd = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			prev_q <= '0;
			acc_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (cap) state_q <= S_PUSH;
				S_PUSH: state_q <= sts.full ? S_IDLE : S_CHK;
				S_CHK: begin
					idx_q <= '0;
					acc_q <= 1'b0;
					state_q <= sts.all_full ? S_MIN : S_IDLE;
				end
				S_MIN, S_EQ, S_POP, S_EMIT: begin
					if (!acc_q) begin
						prev_q <= idx_q;
						acc_q <= 1'b1;
					end else begin
						acc_q <= 1'b0;
						if ({1'b0, prev_q} == ACT_W'(sts.n_act - 1'b1)) begin
							idx_q <= '0;
							case (state_q)
								S_MIN: state_q <= S_EQ;
								S_EQ: state_q <= sts.all_same ? S_EMIT : S_POP;
								S_POP: state_q <= S_CHK;
								default: state_q <= S_IDLE;
							endcase
						end else begin
							idx_q <= prev_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### rtl/exact_time_stream_aligner.sv
// Top level of the exact-time stream aligner.
// Depends on etsa_pkg, etsa_ctrl and etsa_datapath.
//
//  channel  | handshake        | fields
//  ---------+------------------+------------------------------------------
//  input    | start / busy     | channel stamp_sec stamp_nanosec payload
//  result   | strobe (1 cycle) | status out_channel out_payload match_sec
//           |                  |   match_nanosec last
//  config   | cfg_we           | cfg_data (active_channels)
//
// An accepted item goes through a push state, then each scan round takes a
// check state plus three passes over the N active heads (min, equal,
// then pop or emit), all through the single read port of the queue memory.
// A pop round loops back to the check; an item that leaves a queue empty is
// done after the check, and a round that emits ends after its emit pass.
// Full-queue items put their status result out from the push state through
// the result register. Reset empties all queues and sets the active count to 2.
// The receiver cannot stall results.
module exact_time_stream_aligner import etsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [2:0] channel,
	input  logic signed [31:0] stamp_sec,
	input  logic [31:0] stamp_nanosec,
	input  logic [31:0] payload,
	input  logic cfg_we,
	input  logic [3:0] cfg_data,
	output logic strobe,
	output logic status,
	output logic [2:0] out_channel,
	output logic [31:0] out_payload,
	output logic signed [31:0] match_sec,
	output logic [31:0] match_nanosec,
	output logic last
);
	etsa_cmd_t cmd;
	etsa_sts_t sts;
	logic cap, in_active;

	etsa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .in_active(in_active),
		.sts(sts), .busy(busy), .cap(cap), .cmd(cmd)
	);

	etsa_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cap(cap), .channel(channel),
		.stamp_sec(stamp_sec), .stamp_nanosec(stamp_nanosec), .payload(payload),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
		.in_active(in_active), .strobe(strobe), .status(status),
		.out_channel(out_channel), .out_payload(out_payload),
		.match_sec(match_sec), .match_nanosec(match_nanosec), .last(last)
	);
endmodule

### test/etsa_checker.sv
`timescale 1ns / 1ps
// Result checker for the exact-time stream aligner: models the channel queues,
// predicts matched sets and full-queue drops, and compares each strobed result.
// Depends on etsa_pkg for MAX_CHANNELS and QUEUE_DEPTH.
module etsa_checker import etsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic [2:0] channel,
	input  logic signed [31:0] stamp_sec,
	input  logic [31:0] stamp_nanosec,
	input  logic [31:0] payload,
	input  logic cfg_we,
	input  logic [3:0] cfg_data,
	input  logic strobe,
	input  logic status,
	input  logic [2:0] out_channel,
	input  logic [31:0] out_payload,
	input  logic signed [31:0] match_sec,
	input  logic [31:0] match_nanosec,
	input  logic last,
	output int fail_count,
	output int pending,
	output int matched_sets,
	output int drops
);
	typedef struct {
		logic        status;
		logic [2:0]  out_channel;
		logic [31:0] out_payload;
		logic [31:0] match_sec;
		logic [31:0] match_nanosec;
		logic        last;
	} aligned_t;

	typedef struct {
		logic [63:0] stamp;
		logic [31:0] payload;
	} msg_t;

	msg_t chan_q [MAX_CHANNELS][$];
	aligned_t expected_q [$];
	logic [3:0] active_cnt;

	assign pending = expected_q.size();

	// sign-flipped stamp orders signed seconds, then unsigned nanoseconds
	function automatic logic [63:0] order_of(logic [63:0] s);
		return s ^ 64'h8000_0000_0000_0000;
	endfunction

	task automatic align_push(logic [2:0] ch, logic [31:0] sec, logic [31:0] ns,
			logic [31:0] pay);
		int n;
		logic [63:0] lo;
		bit same;
		aligned_t r;
		msg_t m;
		n = (active_cnt > MAX_CHANNELS) ? MAX_CHANNELS : active_cnt;
		if (ch >= n) return;
		if (chan_q[ch].size() >= QUEUE_DEPTH) begin
			r = '{1'b1, ch, pay, sec, ns, 1'b1};
			expected_q.push_back(r);
			drops++;
			return;
		end
		m.stamp = {sec, ns};
		m.payload = pay;
		chan_q[ch].push_back(m);
		forever begin
			for (int c = 0; c < n; c++)
				if (chan_q[c].size() == 0) return;
			lo = order_of(chan_q[0][0].stamp);
			for (int c = 1; c < n; c++)
				if (order_of(chan_q[c][0].stamp) < lo) lo = order_of(chan_q[c][0].stamp);
			same = 1;
			for (int c = 0; c < n; c++)
				if (order_of(chan_q[c][0].stamp) != lo) same = 0;
			if (same) begin
				for (int c = 0; c < n; c++) begin
					m = chan_q[c].pop_front();
					r = '{1'b0, c[2:0], m.payload, m.stamp[63:32], m.stamp[31:0],
						c == n - 1};
					expected_q.push_back(r);
				end
				matched_sets++;
				return;
			end
			for (int c = 0; c < n; c++)
				if (order_of(chan_q[c][0].stamp) == lo) void'(chan_q[c].pop_front());
		end
	endtask

	// input and config side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_cnt <= 4'd2;
			for (int c = 0; c < MAX_CHANNELS; c++) chan_q[c].delete();
			expected_q.delete();
		end else begin
			if (cfg_we) active_cnt <= cfg_data;
			if (start && !busy) align_push(channel, stamp_sec, stamp_nanosec, payload);
		end
	end

	// result side
	initial begin
		fail_count = 0;
		matched_sets = 0;
		drops = 0;
	end

	always @(posedge clk) begin
		aligned_t e;
		if (arst_n && strobe) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result: channel %0d payload %h", out_channel, out_payload);
				fail_count++;
			end else begin
				e = expected_q.pop_front();
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status); fail_count++;
				end
				if (out_channel !== e.out_channel) begin
					$error("out_channel: expected %0d, got %0d", e.out_channel, out_channel);
					fail_count++;
				end
				if (out_payload !== e.out_payload) begin
					$error("out_payload: expected %h, got %h", e.out_payload, out_payload);
					fail_count++;
				end
				if (match_sec !== e.match_sec) begin
					$error("match_sec: expected %h, got %h", e.match_sec, match_sec);
					fail_count++;
				end
				if (match_nanosec !== e.match_nanosec) begin
					$error("match_nanosec: expected %h, got %h", e.match_nanosec,
						match_nanosec);
					fail_count++;
				end
				if (last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, last); fail_count++;
				end
			end
		end
	end
endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Testbench top for the exact-time stream aligner: clock, reset, config phases
// and timestamped item stimulus. Depends on etsa_pkg, the RTL and etsa_checker.
module tb;
	import etsa_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [2:0] channel = '0;
	logic signed [31:0] stamp_sec = '0;
	logic [31:0] stamp_nanosec = '0;
	logic [31:0] payload = '0;
	logic cfg_we = 0;
	logic [3:0] cfg_data = '0;
	logic strobe, status, last;
	logic [2:0] out_channel;
	logic [31:0] out_payload, match_nanosec;
	logic signed [31:0] match_sec;
	int fail_count, pending, matched_sets, drops;
	int sent;
	logic [31:0] base_sec, base_ns;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	exact_time_stream_aligner u_top (.*);
	etsa_checker u_chk (.*);

	// present one item, hold until accepted
	task automatic send_item(logic [2:0] ch, logic [31:0] sec, logic [31:0] ns,
			logic [31:0] pay);
		start = 1;
		channel = ch;
		stamp_sec = sec;
		stamp_nanosec = ns;
		payload = pay;
		do @(posedge clk); while (busy);
		@(negedge clk);
		start = 0;
		sent++;
	endtask

	task automatic random_gap();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	// drain results and wait for the scan to finish before touching config
	task automatic settle();
		while (pending != 0 || busy) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic set_active(logic [3:0] v);
		settle();
		cfg_we <= 1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// a set on channels 0..n-1, sometimes with stale or skewed stamps
	task automatic send_set(int n);
		int order [8];
		int j, t;
		logic [31:0] sec, ns;
		for (int i = 0; i < n; i++) order[i] = i;
		for (int i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i]; order[i] = order[j]; order[j] = t;
		end
		base_ns = base_ns + $urandom_range(1, 1000);
		for (int i = 0; i < n; i++) begin
			sec = base_sec;
			ns = base_ns;
			if ($urandom_range(0, 9) == 0) ns = ns + $urandom_range(1, 3);
			if ($urandom_range(0, 29) == 0) ns = $urandom;
			send_item(order[i][2:0], sec, ns, $urandom);
			if ($urandom_range(0, 1) == 0) random_gap();
		end
	endtask

	initial begin
		int n;
		logic [3:0] settings [6] = '{4'd1, 4'd4, 4'd3, 4'd8, 4'd0, 4'd15};
		sent = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: reset count of two, extreme stamps, ordering across sign
		send_item(3'd0, 32'h8000_0000, 32'h0, 32'h0);
		send_item(3'd1, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
		send_item(3'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
		send_item(3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1);
		send_item(3'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
		send_item(3'd3, 32'h0, 32'h0, 32'h1234_5678);
		send_item(3'd7, 32'h0, 32'h0, 32'h1234_5678);
		send_item(3'd0, 32'h0, 32'h1, 32'h2);
		send_item(3'd1, 32'h0, 32'h1, 32'h3);
		// overflow channel 0 with channel 1 idle
		for (int i = 0; i < QUEUE_DEPTH + 3; i++)
			send_item(3'd0, 32'h10, i, $urandom);
		settle();
		send_item(3'd1, 32'h10, 32'h5, 32'hCAFE);

		// random phases over several active counts
		base_sec = $urandom;
		base_ns = 0;
		foreach (settings[k]) begin
			set_active(settings[k]);
			n = (settings[k] > MAX_CHANNELS) ? MAX_CHANNELS : settings[k];
			repeat (24) begin
				random_gap();
				if (n == 0 || $urandom_range(0, 7) == 0)
					send_item(3'($urandom), $urandom, $urandom, $urandom);
				else if ($urandom_range(0, 5) == 0)
					send_item(3'($urandom_range(0, 7)), base_sec, base_ns, $urandom);
				else
					send_set(n);
				if ($urandom_range(0, 40) == 0) settle();
				if ($urandom_range(0, 9) == 0) base_sec = base_sec + 1;
				if ($urandom_range(0, 30) == 0) base_sec = $urandom;
			end
		end
		settle();
		$display("sent %0d items over active counts 0..15: %0d matched sets, %0d drops",
			sent, matched_sets, drops);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule
